// ----- hdl/tsc_pkg.sv -----
package tsc_pkg;

	localparam int NumAttr = 8;
	localparam int AttrW = 25;
	localparam int MagW = 24;
	localparam int CellDepth = 16;
	localparam int CellAw = 4;
	localparam int MaxOut = 7;

	localparam logic [2:0] RegEnable = 3'd0;
	localparam logic [2:0] RegLeft = 3'd1;
	localparam logic [2:0] RegRight = 3'd2;
	localparam logic [2:0] RegTop = 3'd3;
	localparam logic [2:0] RegBottom = 3'd4;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [15:0] u;
		logic signed [15:0] v;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} vertex_t;

	typedef struct packed {
		vertex_t vtx;
		logic last;
		logic nul;
	} word_t;

	function automatic logic signed [AttrW-1:0] attr_get(vertex_t vx, int unsigned k);
		logic signed [AttrW-1:0] res;
		unique case (k)
			0: res = AttrW'(vx.x);
			1: res = AttrW'(vx.y);
			2: res = AttrW'(vx.u);
			3: res = AttrW'(vx.v);
			4: res = signed'(AttrW'(vx.r));
			5: res = signed'(AttrW'(vx.g));
			6: res = signed'(AttrW'(vx.b));
			default: res = signed'(AttrW'(vx.a));
		endcase
		return res;
	endfunction

	function automatic vertex_t attr_set(vertex_t vx, int unsigned k,
			logic signed [AttrW-1:0] val);
		vertex_t res;
		res = vx;
		unique case (k)
			0: res.x = val[23:0];
			1: res.y = val[23:0];
			2: res.u = val[15:0];
			3: res.v = val[15:0];
			4: res.r = val[7:0];
			5: res.g = val[7:0];
			6: res.b = val[7:0];
			default: res.a = val[7:0];
		endcase
		return res;
	endfunction

endpackage

// ----- hdl/tsc_if.sv -----
interface tsc_vin_if;
	logic valid;
	logic ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [15:0] tex_u;
	logic signed [15:0] tex_v;
	logic [7:0] col_red;
	logic [7:0] col_green;
	logic [7:0] col_blue;
	logic [7:0] col_alpha;

	modport source(output valid, output pos_x, output pos_y, output tex_u, output tex_v,
		output col_red, output col_green, output col_blue, output col_alpha, input ready);
	modport sink(input valid, input pos_x, input pos_y, input tex_u, input tex_v,
		input col_red, input col_green, input col_blue, input col_alpha, output ready);
endinterface

interface tsc_vout_if;
	logic valid;
	logic ready;
	logic signed [23:0] out_x;
	logic signed [23:0] out_y;
	logic signed [15:0] out_u;
	logic signed [15:0] out_v;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic [2:0] vertex_position;
	logic polygon_last;

	modport source(output valid, output out_x, output out_y, output out_u, output out_v,
		output out_red, output out_green, output out_blue, output out_alpha,
		output vertex_position, output polygon_last, input ready);
	modport sink(input valid, input out_x, input out_y, input out_u, input out_v,
		input out_red, input out_green, input out_blue, input out_alpha,
		input vertex_position, input polygon_last, output ready);
endinterface

// ----- hdl/tsc_lerp_lane.sv -----
module tsc_lerp_lane #(
	parameter int NUMW = 25
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [tsc_pkg::AttrW-1:0] a,
	input logic signed [tsc_pkg::AttrW-1:0] b,
	input logic [NUMW-1:0] num,
	input logic [NUMW-1:0] den,
	output logic signed [tsc_pkg::AttrW-1:0] res,
	output logic done
);
	localparam int MagW = tsc_pkg::MagW;
	localparam int AttrW = tsc_pkg::AttrW;
	localparam int CntW = $clog2(MagW + 1);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_MUL  = 3'b010,
		L_DIV  = 3'b100
	} lstate_t;

	lstate_t state_q;
	logic [CntW-1:0] cnt_q;
	logic done_q;
	logic signed [AttrW-1:0] diff, a_q;
	logic [MagW-1:0] mag_c, mag_q, quo_q;
	logic neg_q;
	logic [MagW+NUMW-1:0] prod;
	logic [NUMW-1:0] rem_q;
	logic [NUMW:0] rem2, rem_sub, rem_dbl;
	logic ge, up;
	logic [AttrW-1:0] rmag;

	assign diff = b - a;
	assign mag_c = diff[AttrW-1] ? MagW'(-diff) : MagW'(diff);
	assign prod = (MagW+NUMW)'(mag_q) * (MagW+NUMW)'(num);
	assign rem2 = {rem_q, quo_q[MagW-1]};
	assign ge = rem2 >= {1'b0, den};
	assign rem_sub = rem2 - {1'b0, den};
	assign rem_dbl = {rem_q, 1'b0};
	assign up = rem_dbl >= {1'b0, den};
	assign rmag = AttrW'(quo_q) + AttrW'(up);
	assign res = neg_q ? a_q - signed'(rmag) : a_q + signed'(rmag);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						done_q <= 1'b0;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					cnt_q <= CntW'(MagW);
					state_q <= L_DIV;
				end
				L_DIV: begin
					cnt_q <= cnt_q - CntW'(1);
					if (cnt_q == CntW'(1)) begin
						done_q <= 1'b1;
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			a_q <= a;
			mag_q <= mag_c;
			neg_q <= diff[AttrW-1];
		end
		if (state_q == L_MUL) begin
			rem_q <= prod[MagW+NUMW-1:MagW];
			quo_q <= prod[MagW-1:0];
		end
		if (state_q == L_DIV) begin
			rem_q <= ge ? rem_sub[NUMW-1:0] : rem2[NUMW-1:0];
			quo_q <= {quo_q[MagW-2:0], ge};
		end
	end

endmodule

// ----- hdl/tsc_clip_cell.sv -----
module tsc_clip_cell #(
	parameter int FRAC = 8,
	parameter bit AXIS_Y = 1'b0,
	parameter bit KEEP_GREATER = 1'b1
) (
	input logic clk,
	input logic arst_n,
	input logic bypass,
	input logic signed [15:0] clip_px,
	input logic in_valid,
	output logic in_ready,
	input tsc_pkg::word_t in_word,
	output logic out_valid,
	input logic out_ready,
	output tsc_pkg::word_t out_word
);
	localparam int EdgeW = 16 + FRAC;
	localparam int DistW = ((EdgeW > 24) ? EdgeW : 24) + 1;
	localparam int Aw = tsc_pkg::CellAw;
	localparam int NumAttr = tsc_pkg::NumAttr;

	typedef enum logic [9:0] {
		S_FILL   = 10'b0000000001,
		S_RDPREV = 10'b0000000010,
		S_LDPREV = 10'b0000000100,
		S_LDCUR  = 10'b0000001000,
		S_EVAL   = 10'b0000010000,
		S_DIV    = 10'b0000100000,
		S_PUSHI  = 10'b0001000000,
		S_PUSHV  = 10'b0010000000,
		S_RDW    = 10'b0100000000,
		S_FLUSH  = 10'b1000000000
	} cstate_t;

	cstate_t state_q;
	tsc_pkg::vertex_t mem_q [tsc_pkg::CellDepth];
	tsc_pkg::vertex_t rdata_q, prev_q, cur_q, pend_q, ivtx, push_vtx;
	tsc_pkg::word_t out_q;
	logic [Aw:0] cnt_q, cnt_m1;
	logic [Aw-1:0] idx_q, raddr;
	logic signed [DistW-1:0] edge_c, pos_rd, c_rd, dist_rd, dp_q, d_q;
	logic [DistW-1:0] num_q, den_q;
	logic pin_q, cin_q, in_rd, pend_v_q, out_v_q;
	logic [NumAttr-1:0] lane_done;
	logic signed [tsc_pkg::AttrW-1:0] lane_res [NumAttr];
	logic can_push, push_req, push, flush_go, lane_start, last_idx, adv;

	assign edge_c = DistW'(clip_px) <<< FRAC;
	assign pos_rd = AXIS_Y ? DistW'(rdata_q.y) : DistW'(rdata_q.x);
	assign c_rd = pos_rd - edge_c;
	assign dist_rd = KEEP_GREATER ? c_rd : -c_rd;
	assign in_rd = bypass || !dist_rd[DistW-1];

	assign cnt_m1 = cnt_q - (Aw+1)'(1);
	assign raddr = (state_q == S_RDPREV) ? cnt_m1[Aw-1:0] : idx_q;
	assign last_idx = ({1'b0, idx_q} == cnt_m1);
	assign in_ready = (state_q == S_FILL);

	assign can_push = !pend_v_q || !out_v_q || out_ready;
	assign push_req = (state_q == S_PUSHI) || (state_q == S_PUSHV && cin_q);
	assign push = push_req && can_push;
	assign push_vtx = (state_q == S_PUSHI) ? ivtx : cur_q;
	assign adv = (state_q == S_PUSHV) && (!cin_q || can_push);
	assign flush_go = (state_q == S_FLUSH) && (!out_v_q || out_ready);
	assign lane_start = (state_q == S_EVAL) && (cin_q != pin_q);

	assign out_valid = out_v_q;
	assign out_word = out_q;

	for (genvar k = 0; k < NumAttr; k++) begin : g_lane
		tsc_lerp_lane #(.NUMW(DistW)) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.start(lane_start),
			.a(tsc_pkg::attr_get(prev_q, k)),
			.b(tsc_pkg::attr_get(cur_q, k)),
			.num(num_q),
			.den(den_q),
			.res(lane_res[k]),
			.done(lane_done[k])
		);
	end

	always_comb begin
		ivtx = cur_q;
		for (int k = 0; k < NumAttr; k++) begin
			ivtx = tsc_pkg::attr_set(ivtx, k, lane_res[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				S_FILL: begin
					if (in_valid) begin
						if (!in_word.nul) begin
							cnt_q <= cnt_q + (Aw+1)'(1);
						end
						if (in_word.last) begin
							idx_q <= '0;
							if (in_word.nul && cnt_q == '0) begin
								state_q <= S_FLUSH;
							end else begin
								state_q <= S_RDPREV;
							end
						end
					end
				end
				S_RDPREV: state_q <= S_LDPREV;
				S_LDPREV: state_q <= S_LDCUR;
				S_LDCUR: state_q <= S_EVAL;
				S_EVAL: state_q <= (cin_q != pin_q) ? S_DIV : S_PUSHV;
				S_DIV: begin
					if (&lane_done) begin
						state_q <= S_PUSHI;
					end
				end
				S_PUSHI: begin
					if (can_push) begin
						state_q <= S_PUSHV;
					end
				end
				S_PUSHV: begin
					if (adv) begin
						if (last_idx) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q <= idx_q + Aw'(1);
							state_q <= S_RDW;
						end
					end
				end
				S_RDW: state_q <= S_LDCUR;
				S_FLUSH: begin
					if (flush_go) begin
						cnt_q <= '0;
						state_q <= S_FILL;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (flush_go) begin
				out_v_q <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (push && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (push) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FILL && in_valid && !in_word.nul) begin
			mem_q[cnt_q[Aw-1:0]] <= in_word.vtx;
		end
		rdata_q <= mem_q[raddr];
		if (state_q == S_LDPREV) begin
			prev_q <= rdata_q;
			dp_q <= dist_rd;
			pin_q <= in_rd;
		end
		if (state_q == S_LDCUR) begin
			cur_q <= rdata_q;
			d_q <= dist_rd;
			cin_q <= in_rd;
		end
		if (state_q == S_EVAL) begin
			if (!dp_q[DistW-1]) begin
				num_q <= unsigned'(dp_q);
				den_q <= unsigned'(dp_q - d_q);
			end else begin
				num_q <= unsigned'(-dp_q);
				den_q <= unsigned'(d_q - dp_q);
			end
		end
		if (adv) begin
			prev_q <= cur_q;
			dp_q <= d_q;
			pin_q <= cin_q;
		end
		if (flush_go) begin
			out_q.vtx <= pend_q;
			out_q.last <= 1'b1;
			out_q.nul <= !pend_v_q;
		end else if (push && pend_v_q) begin
			out_q.vtx <= pend_q;
			out_q.last <= 1'b0;
			out_q.nul <= 1'b0;
		end
		if (push) begin
			pend_q <= push_vtx;
		end
	end

endmodule

// ----- hdl/tsc_collect.sv -----
module tsc_collect (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tsc_pkg::word_t in_word,
	tsc_vout_if.source vout
);
	typedef enum logic [1:0] {
		C_FILL = 2'b01,
		C_EMIT = 2'b10
	} kstate_t;

	kstate_t state_q;
	tsc_pkg::vertex_t buf_q [tsc_pkg::MaxOut];
	tsc_pkg::vertex_t o_vtx_q;
	logic [2:0] cnt_q, eidx_q, cnt_nx, o_pos_q;
	logic o_last_q, ov_q, store, load, e_last;

	assign in_ready = (state_q == C_FILL);
	assign store = in_valid && !in_word.nul && (cnt_q != 3'(tsc_pkg::MaxOut));
	assign cnt_nx = store ? cnt_q + 3'd1 : cnt_q;
	assign load = (state_q == C_EMIT) && (!ov_q || vout.ready);
	assign e_last = (eidx_q == cnt_q - 3'd1);

	assign vout.valid = ov_q;
	assign vout.out_x = o_vtx_q.x;
	assign vout.out_y = o_vtx_q.y;
	assign vout.out_u = o_vtx_q.u;
	assign vout.out_v = o_vtx_q.v;
	assign vout.out_red = o_vtx_q.r;
	assign vout.out_green = o_vtx_q.g;
	assign vout.out_blue = o_vtx_q.b;
	assign vout.out_alpha = o_vtx_q.a;
	assign vout.vertex_position = o_pos_q;
	assign vout.polygon_last = o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_FILL;
			cnt_q <= '0;
			eidx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q <= 1'b1;
			end else if (vout.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				C_FILL: begin
					if (in_valid) begin
						if (in_word.last) begin
							eidx_q <= '0;
							if (cnt_nx >= 3'd3) begin
								cnt_q <= cnt_nx;
								state_q <= C_EMIT;
							end else begin
								cnt_q <= '0;
							end
						end else begin
							cnt_q <= cnt_nx;
						end
					end
				end
				C_EMIT: begin
					if (load) begin
						if (e_last) begin
							cnt_q <= '0;
							state_q <= C_FILL;
						end else begin
							eidx_q <= eidx_q + 3'd1;
						end
					end
				end
				default: state_q <= C_FILL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_FILL && store) begin
			buf_q[cnt_q] <= in_word.vtx;
		end
		if (load) begin
			o_vtx_q <= buf_q[eidx_q];
			o_pos_q <= eidx_q;
			o_last_q <= e_last;
		end
	end

endmodule

// ----- hdl/triangle_scissor_clipper_unit.sv -----
// Channel   Modport       Word
// vin       sink          one vertex: position, texture coordinate, color
// vout      source        one polygon vertex with its index and last mark
// cfg_*     write only    scissor enable and the four scissor edges
//
// Vertices are taken one per cycle; after the third one vin.ready stays low until the triangle's
// words have entered the first of four clipping cells in a row (left, right, top, bottom),
// which takes them only once it has finished the previous triangle.
// At each edge crossing, a cell's eight interpolation lanes run a 24-step division. Reset is
// asynchronous and needs no clearing pass.
// Stalls on vout hold the output word and back up through the cells to vin.
module triangle_scissor_clipper_unit #(
	parameter int POSITION_FRACTION_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	tsc_vin_if.sink vin,
	tsc_vout_if.source vout
);
	logic en_q;
	logic signed [15:0] left_q, right_q, top_q, bottom_q;
	logic [1:0] phase_q, fidx_q;
	logic feeding_q, drop_q, hsel, accept, empty_rect;
	tsc_pkg::vertex_t cur_c, held0_q, held1_q, held2_q;
	tsc_pkg::word_t feed_word;
	logic [4:0] lk_valid, lk_ready;
	tsc_pkg::word_t lk_word [5];

	assign cur_c = '{x: vin.pos_x, y: vin.pos_y, u: vin.tex_u, v: vin.tex_v,
		r: vin.col_red, g: vin.col_green, b: vin.col_blue, a: vin.col_alpha};
	assign vin.ready = !feeding_q;
	assign accept = vin.valid && !feeding_q;
	assign hsel = (phase_q == 2'd1);
	assign empty_rect = en_q && ((right_q <= left_q) || (bottom_q <= top_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
			left_q <= '0;
			right_q <= '0;
			top_q <= '0;
			bottom_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsc_pkg::RegEnable: en_q <= cfg_data[0];
				tsc_pkg::RegLeft: left_q <= cfg_data;
				tsc_pkg::RegRight: right_q <= cfg_data;
				tsc_pkg::RegTop: top_q <= cfg_data;
				tsc_pkg::RegBottom: bottom_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			fidx_q <= '0;
			feeding_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			if (accept) begin
				if (phase_q == 2'd2) begin
					phase_q <= '0;
					feeding_q <= 1'b1;
					fidx_q <= '0;
					drop_q <= empty_rect;
				end else begin
					phase_q <= hsel ? 2'd2 : 2'd1;
				end
			end else if (feeding_q && lk_ready[0]) begin
				if (feed_word.last) begin
					feeding_q <= 1'b0;
				end else begin
					fidx_q <= fidx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (phase_q == 2'd2) begin
				held2_q <= cur_c;
			end else if (hsel) begin
				held1_q <= cur_c;
			end else begin
				held0_q <= cur_c;
			end
		end
	end

	always_comb begin
		feed_word.vtx = held2_q;
		if (fidx_q == 2'd0) begin
			feed_word.vtx = held0_q;
		end else if (fidx_q == 2'd1) begin
			feed_word.vtx = held1_q;
		end
		feed_word.last = drop_q || (fidx_q == 2'd2);
		feed_word.nul = drop_q;
	end

	assign lk_valid[0] = feeding_q;
	assign lk_word[0] = feed_word;

	tsc_clip_cell #(.FRAC(POSITION_FRACTION_BITS), .AXIS_Y(1'b0), .KEEP_GREATER(1'b1)) u_left (
		.clk(clk), .arst_n(arst_n), .bypass(!en_q), .clip_px(left_q),
		.in_valid(lk_valid[0]), .in_ready(lk_ready[0]), .in_word(lk_word[0]),
		.out_valid(lk_valid[1]), .out_ready(lk_ready[1]), .out_word(lk_word[1])
	);

	tsc_clip_cell #(.FRAC(POSITION_FRACTION_BITS), .AXIS_Y(1'b0), .KEEP_GREATER(1'b0)) u_right (
		.clk(clk), .arst_n(arst_n), .bypass(!en_q), .clip_px(right_q),
		.in_valid(lk_valid[1]), .in_ready(lk_ready[1]), .in_word(lk_word[1]),
		.out_valid(lk_valid[2]), .out_ready(lk_ready[2]), .out_word(lk_word[2])
	);

	tsc_clip_cell #(.FRAC(POSITION_FRACTION_BITS), .AXIS_Y(1'b1), .KEEP_GREATER(1'b1)) u_top (
		.clk(clk), .arst_n(arst_n), .bypass(!en_q), .clip_px(top_q),
		.in_valid(lk_valid[2]), .in_ready(lk_ready[2]), .in_word(lk_word[2]),
		.out_valid(lk_valid[3]), .out_ready(lk_ready[3]), .out_word(lk_word[3])
	);

	tsc_clip_cell #(.FRAC(POSITION_FRACTION_BITS), .AXIS_Y(1'b1), .KEEP_GREATER(1'b0)) u_bottom (
		.clk(clk), .arst_n(arst_n), .bypass(!en_q), .clip_px(bottom_q),
		.in_valid(lk_valid[3]), .in_ready(lk_ready[3]), .in_word(lk_word[3]),
		.out_valid(lk_valid[4]), .out_ready(lk_ready[4]), .out_word(lk_word[4])
	);

	tsc_collect u_collect (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(lk_valid[4]),
		.in_ready(lk_ready[4]),
		.in_word(lk_word[4]),
		.vout(vout)
	);

endmodule

// ----- hdl/tsc_checker.sv -----
module tsc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic out_last,
	input logic [2:0] out_pos,
	input logic [23:0] out_x
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_x))
		else $error("output word changed while stalled");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_pos <= 3'd6)
		else $error("vertex index beyond seven vertices");

	a_min_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> out_pos >= 3'd2)
		else $error("polygon with fewer than three vertices");

	a_max_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_pos == 3'd6 |-> out_last)
		else $error("seventh vertex not marked last");

	a_next_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=>
			out_valid && out_pos == 3'($past(out_pos) + 3'd1))
		else $error("vertex index did not advance");

endmodule

bind triangle_scissor_clipper_unit tsc_checker u_tsc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(vout.valid),
	.out_ready(vout.ready),
	.out_last(vout.polygon_last),
	.out_pos(vout.vertex_position),
	.out_x(vout.out_x)
);
